[hw/rtl/sacn_pkg.sv]
// Shared types and constants for the set-associative NRU cache unit.
// No dependencies; imported by every module of the block except sacn_ram.
`timescale 1ns / 1ps
`default_nettype none

package sacn_pkg;

	localparam int ADDR_W    = 32;
	localparam int TAG_W     = 32;
	localparam int OFFSET_W  = 5;
	localparam int INDEX_W   = 3;
	localparam int WAYS_W    = 4;
	localparam int CIDX_W    = 2;
	localparam int CDATA_W   = 5;
	localparam int OUT_WAY_W = 3;
	localparam int CNT_W     = 32;

	localparam logic [OFFSET_W-1:0] OFFSET_RST = 5'd2;
	localparam logic [INDEX_W-1:0]  INDEX_RST  = 3'd6;
	localparam logic [WAYS_W-1:0]   WAYS_RST   = 4'd8;

	typedef enum logic [CIDX_W-1:0] {
		REG_OFFSET_BITS = 2'd0,
		REG_INDEX_BITS  = 2'd1,
		REG_WAYS_IN_USE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset_bits;
		logic [INDEX_W-1:0]  index_bits;
		logic [WAYS_W-1:0]   ways_in_use;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_LOOK  = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

endpackage

`default_nettype wire

[hw/rtl/sacn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the tag store and the per-set NRU/valid rows.
`timescale 1ns / 1ps
`default_nettype none

module sacn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	input  wire logic                                   rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/sacn_addr_split.sv]
// Splits an access address into set index and tag under the current config.
// Depends on sacn_pkg for the config struct and field widths.
`timescale 1ns / 1ps
`default_nettype none

module sacn_addr_split
	import sacn_pkg::*;
#(
	parameter int MAX_SETS  = 64,
	parameter int ADDR_BITS = 32
) (
	input  wire logic [ADDR_W-1:0]                          address,
	input  wire cfg_t                                       cfg,
	output logic      [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] set_idx,
	output logic      [TAG_W-1:0]                           tag
);

	localparam int SET_W   = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
	localparam int IDX_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? '1 :
		ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

	logic [ADDR_W-1:0]  addr_m;
	logic [INDEX_W-1:0] idx_eff;
	logic [ADDR_W-1:0]  shifted;
	logic [ADDR_W-1:0]  set_mask;
	logic [5:0]         tag_shift;

	always_comb begin
		addr_m = address & ADDR_MASK;
		// the index field cannot address more sets than exist; extra bits go to the tag
		if (int'(cfg.index_bits) > IDX_MAX) begin
			idx_eff = INDEX_W'(IDX_MAX);
		end else begin
			idx_eff = cfg.index_bits;
		end
		shifted   = addr_m >> cfg.offset_bits;
		set_mask  = (ADDR_W'(1) << idx_eff) - ADDR_W'(1);
		set_idx   = SET_W'(shifted & set_mask);
		tag_shift = 6'(cfg.offset_bits) + 6'(idx_eff);
		if (tag_shift >= 6'(ADDR_W)) begin
			tag = '0;
		end else begin
			tag = TAG_W'(addr_m >> tag_shift);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/sacn_nru_sel.sv]
// Picks the way used by an access and the updated NRU row of its set.
// Depends on sacn_pkg for the width of the reported way.
`timescale 1ns / 1ps
`default_nettype none

module sacn_nru_sel
	import sacn_pkg::*;
#(
	parameter int MAX_WAYS = 8
) (
	input  wire logic [MAX_WAYS-1:0]                          nru_row,
	input  wire logic [$clog2(MAX_WAYS + 1)-1:0]              ways,
	input  wire logic                                         hit,
	input  wire logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] hit_way,
	output logic      [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] way_used,
	output logic      [OUT_WAY_W-1:0]                         way_out,
	output logic      [MAX_WAYS-1:0]                          nru_next
);

	localparam int WAY_W = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;

	logic             found;
	logic [WAY_W-1:0] victim;

	always_comb begin
		found  = 1'b0;
		victim = '0;
		// scan from the top so the lowest marked way wins
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (i < int'(ways) && nru_row[i]) begin
				found  = 1'b1;
				victim = WAY_W'(i);
			end
		end
		way_used = hit ? hit_way : victim;
		way_out  = OUT_WAY_W'(way_used);
		nru_next = nru_row;
		// no candidate: re-arm every in-use way, then fill way 0
		if (!hit && !found) begin
			for (int i = 0; i < MAX_WAYS; i++) begin
				if (i < int'(ways)) begin
					nru_next[i] = 1'b1;
				end
			end
		end
		nru_next[way_used] = 1'b0;
	end

endmodule

`default_nettype wire

[hw/rtl/set_assoc_cache_nru_unit.sv]
// Top level of the tag-only set-associative cache with NRU replacement.
// Depends on sacn_pkg, sacn_ram, sacn_addr_split and sacn_nru_sel.
`timescale 1ns / 1ps
`default_nettype none

// Each address item is looked up in its set by one tag comparator that steps
// over the ways, one tag RAM read per cycle, until a hit or the last in-use way.
// An item takes an accept step, a compare per way read (1 up to ways_in_use) and
// a write-back of the NRU/valid row, the tag on a miss and the miss counter,
// which waits while a held result is stalled. The next item is taken in the cycle
// after the write-back, while the result may still wait in the output register.
// After reset a clearing pass over the MAX_SETS sets resets their NRU/valid rows;
// no item is accepted during it, configuration writes are. Configuration changes
// do not flush the cache and must be made only while the block is idle.
module set_assoc_cache_nru_unit
	import sacn_pkg::*;
#(
	parameter int MAX_SETS  = 64,
	parameter int MAX_WAYS  = 8,
	parameter int ADDR_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [ADDR_W-1:0]    address,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      hit,
	output logic      [OUT_WAY_W-1:0] way,
	output logic      [CNT_W-1:0]     miss_total,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CIDX_W-1:0]    cfg_index,
	input  wire logic [CDATA_W-1:0]   cfg_data
);

	localparam int SET_W     = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W     = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
	localparam int TAG_DEPTH = MAX_SETS * MAX_WAYS;
	localparam int TAG_AW    = TAG_DEPTH > 1 ? $clog2(TAG_DEPTH) : 1;
	localparam int META_W    = 2 * MAX_WAYS;

	state_t             state_q;
	cfg_t               cfg_q;
	logic [SET_W-1:0]   clr_q;
	logic [SET_W-1:0]   set_q;
	logic [TAG_AW-1:0]  base_q;
	logic [TAG_W-1:0]   tag_q;
	logic [WAY_W-1:0]   w_q;
	logic               hit_q;
	logic [WAY_W-1:0]   hit_way_q;
	logic [CNT_W-1:0]   miss_cnt_q;
	logic               out_valid_q;
	logic               out_hit_q;
	logic [OUT_WAY_W-1:0] out_way_q;

	logic [SET_W-1:0]   set_c;
	logic [TAG_W-1:0]   tag_c;
	logic [WCNT_W-1:0]  ways_eff;
	logic               in_acc;
	logic               match;
	logic               last_way;
	logic               wr_go;
	logic [WAY_W-1:0]   w_nxt;

	logic               tag_rd_en;
	logic [TAG_AW-1:0]  tag_rd_addr;
	logic [TAG_W-1:0]   tag_rd;
	logic [TAG_AW-1:0]  tag_wr_addr;

	logic               meta_wr_en;
	logic [SET_W-1:0]   meta_wr_addr;
	logic [META_W-1:0]  meta_wr_data;
	logic [META_W-1:0]  meta_rd;
	logic [MAX_WAYS-1:0] valid_row;
	logic [MAX_WAYS-1:0] nru_row;
	logic [MAX_WAYS-1:0] valid_next;
	logic [MAX_WAYS-1:0] nru_next;
	logic [WAY_W-1:0]   way_used;
	logic [OUT_WAY_W-1:0] way_out;

	sacn_addr_split #(
		.MAX_SETS (MAX_SETS),
		.ADDR_BITS(ADDR_BITS)
	) u_split (
		.address(address),
		.cfg    (cfg_q),
		.set_idx(set_c),
		.tag    (tag_c)
	);

	sacn_nru_sel #(
		.MAX_WAYS(MAX_WAYS)
	) u_nru (
		.nru_row (nru_row),
		.ways    (ways_eff),
		.hit     (hit_q),
		.hit_way (hit_way_q),
		.way_used(way_used),
		.way_out (way_out),
		.nru_next(nru_next)
	);

	sacn_ram #(
		.WIDTH(TAG_W),
		.DEPTH(TAG_DEPTH)
	) u_tag_ram (
		.clk    (clk),
		.wr_en  (wr_go && !hit_q),
		.wr_addr(tag_wr_addr),
		.wr_data(tag_q),
		.rd_en  (tag_rd_en),
		.rd_addr(tag_rd_addr),
		.rd_data(tag_rd)
	);

	sacn_ram #(
		.WIDTH(META_W),
		.DEPTH(MAX_SETS)
	) u_meta_ram (
		.clk    (clk),
		.wr_en  (meta_wr_en),
		.wr_addr(meta_wr_addr),
		.wr_data(meta_wr_data),
		.rd_en  (in_acc),
		.rd_addr(set_c),
		.rd_data(meta_rd)
	);

	always_comb begin
		if (cfg_q.ways_in_use == '0) begin
			ways_eff = WCNT_W'(1);
		end else if (int'(cfg_q.ways_in_use) > MAX_WAYS) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WCNT_W'(cfg_q.ways_in_use);
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign {nru_row, valid_row} = meta_rd;
	assign match      = valid_row[w_q] && (tag_rd == tag_q);
	assign last_way   = (WCNT_W'(w_q) == ways_eff - WCNT_W'(1));
	assign wr_go      = (state_q == ST_WRITE) && (!out_valid_q || !out_stall);
	assign w_nxt      = w_q + WAY_W'(1);
	assign tag_wr_addr = base_q + TAG_AW'(way_used);

	always_comb begin
		valid_next           = valid_row;
		valid_next[way_used] = 1'b1;
	end

	// tag read: way 0 on accept, then the next way while the compare misses and the last in-use way is not reached
	always_comb begin
		tag_rd_en   = 1'b0;
		tag_rd_addr = base_q + TAG_AW'(w_nxt);
		if (in_acc) begin
			tag_rd_en   = 1'b1;
			tag_rd_addr = TAG_AW'(set_c) * TAG_AW'(MAX_WAYS);
		end else if (state_q == ST_LOOK && !match && !last_way) begin
			tag_rd_en = 1'b1;
		end
	end

	always_comb begin
		meta_wr_en   = 1'b0;
		meta_wr_addr = set_q;
		meta_wr_data = {nru_next, valid_next};
		if (state_q == ST_CLEAR) begin
			meta_wr_en   = 1'b1;
			meta_wr_addr = clr_q;
			meta_wr_data = {{MAX_WAYS{1'b1}}, {MAX_WAYS{1'b0}}};
		end else if (wr_go) begin
			meta_wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			w_q         <= '0;
			hit_q       <= 1'b0;
			miss_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == SET_W'(MAX_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						w_q     <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_WRITE;
					end else if (last_way) begin
						state_q <= ST_WRITE;
					end else begin
						w_q <= w_nxt;
					end
				end
				ST_WRITE: begin
					if (wr_go) begin
						if (!hit_q && miss_cnt_q != '1) begin
							miss_cnt_q <= miss_cnt_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase

			if (wr_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload and result fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			set_q  <= set_c;
			base_q <= TAG_AW'(set_c) * TAG_AW'(MAX_WAYS);
			tag_q  <= tag_c;
		end
		if (state_q == ST_LOOK && match) begin
			hit_way_q <= w_q;
		end
		if (wr_go) begin
			out_hit_q <= hit_q;
			out_way_q <= way_out;
		end
	end

	// config registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_bits <= OFFSET_RST;
			cfg_q.index_bits  <= INDEX_RST;
			cfg_q.ways_in_use <= WAYS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OFFSET_BITS: cfg_q.offset_bits <= cfg_data[OFFSET_W-1:0];
				REG_INDEX_BITS:  cfg_q.index_bits  <= cfg_data[INDEX_W-1:0];
				REG_WAYS_IN_USE: cfg_q.ways_in_use <= cfg_data[WAYS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign hit        = out_hit_q;
	assign way        = out_way_q;
	assign miss_total = miss_cnt_q;

	a_result_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WRITE))
		else $error("result appeared without a write-back");

	a_miss_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		miss_cnt_q >= $past(miss_cnt_q))
		else $error("miss count went down");

	a_hit_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_go && hit_q) |=> $stable(miss_cnt_q))
		else $error("hit changed the miss count");

endmodule

`default_nettype wire
